// ===== rtl/first_fit_heap_allocator_macros.svh =====
// Assertion helpers used by the allocator controller (ffha_ctrl).
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define FFHA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define FFHA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ffha_pkg.sv =====
`default_nettype none
package ffha_pkg;

  typedef struct packed {
    logic        opcode;
    logic [15:0] request_size;
    logic [15:0] payload_address;
  } ffha_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [11:0] result_address;
    logic [11:0] granted_size;
    logic [10:0] used_blocks;
  } ffha_out_t;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOSPACE  = 3'd1;
  localparam logic [2:0] ST_ZERO     = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_NOTALLOC = 3'd4;
  localparam logic [2:0] ST_DOUBLE   = 3'd5;

  localparam int FIRST_HDR = 2;
  localparam int HDR_BYTES = 2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;
    logic       start;
    logic       walk_adv;
    logic       take;
    logic       split_wr;
    logic       free_mark;
    logic       cfirst;
    logic       cstep;
    logic       set_st;
    logic [2:0] st;
    logic       finish;
  } ffha_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_free;
    logic zero_req;
    logic bad_range;
    logic hdr_free;
    logic fit;
    logic split;
    logic at_target;
    logic walk_end;
    logic cs_end;
  } ffha_stat_t;

endpackage
`default_nettype wire

// ===== rtl/first_fit_heap_allocator.sv =====
// An allocate walks the blocks to the first fit, then writes a split header if the block splits;
//   a free walks to its header, then merges free blocks in a pass from the first header.
// One item at a time, bounded by one header read per cycle; zero/range rejects skip the walk.
// Reset (rst_n low, synchronous): one free block at offset 2, no blocks used, no result.
// The header RAM needs no clearing pass; only the first header is held in flops.
`default_nettype none
module first_fit_heap_allocator #(
  parameter int HEAP_BYTES = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire ffha_pkg::ffha_in_t in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output ffha_pkg::ffha_out_t     out_data
);
  import ffha_pkg::*;

  // Controller sequences the chain walk; the datapath holds the header RAM,
  // walk pointer, use count and the result register.
  ffha_cmd_t  cmd;
  ffha_stat_t stat;

  ffha_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ffha_datapath #(
    .HEAP_BYTES(HEAP_BYTES)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_data (in_data),
    .cmd     (cmd),
    .stat    (stat),
    .out_data(out_data)
  );

endmodule
`default_nettype wire

// ===== rtl/ffha_ram.sv =====
`default_nettype none
module ffha_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/ffha_datapath.sv =====
`default_nettype none
module ffha_datapath #(
  parameter int HEAP_BYTES = 4096
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire ffha_pkg::ffha_in_t  in_data,
  input  wire ffha_pkg::ffha_cmd_t cmd,
  output ffha_pkg::ffha_stat_t     stat,
  output ffha_pkg::ffha_out_t      out_data
);
  import ffha_pkg::*;

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int PW = AW + 1;
  localparam int HW = AW + 1;
  localparam logic [PW-1:0] HEAP_END = PW'(HEAP_BYTES);
  localparam logic [PW-1:0] HDR_P    = PW'(HDR_BYTES);
  localparam logic [PW-1:0] FIRST_P  = PW'(FIRST_HDR);
  localparam logic signed [HW-1:0] HDR2_RESET = HW'(-(HEAP_BYTES - FIRST_HDR - HDR_BYTES));

  ffha_in_t               req_r;
  logic [PW-1:0]          p_r;
  logic signed [HW-1:0]   s_r;
  logic signed [HW-1:0]   hdr2_r;
  logic                   rd2_r;
  logic [AW-1:0]          addr_r;
  logic [AW-1:0]          gr_r;
  logic [AW-1:0]          used_r;
  logic [2:0]             st_r;
  ffha_out_t              out_r;

  logic [HW-1:0]          ram_rd;
  logic signed [HW-1:0]   rdata;
  logic signed [HW-1:0]   abs_d, abs_s;
  logic [AW-1:0]          mag_d, mag_s, mag_m;
  logic [PW-1:0]          next_d, n_s, c_next;
  logic [16:0]            size17, mag17, addr17;
  logic                   merge;
  logic [PW-1:0]          raddr;
  logic                   wen;
  logic [PW-1:0]          waddr;
  logic signed [HW-1:0]   wdata;
  logic [31:0]            addr_w, gr_w, used_w;

  assign rdata  = rd2_r ? hdr2_r : $signed(ram_rd);
  assign abs_d  = rdata[HW-1] ? -rdata : rdata;
  assign abs_s  = s_r[HW-1] ? -s_r : s_r;
  assign mag_d  = abs_d[AW-1:0];
  assign mag_s  = abs_s[AW-1:0];
  assign mag_m  = mag_s + mag_d + AW'(HDR_BYTES);
  assign next_d = p_r + PW'(mag_d) + HDR_P;
  assign n_s    = p_r + PW'(mag_s) + HDR_P;
  assign merge  = s_r[HW-1] && rdata[HW-1];
  assign c_next = merge ? (p_r + PW'(mag_m) + HDR_P) : (n_s + PW'(mag_d) + HDR_P);
  assign size17 = {1'b0, req_r.request_size};
  assign mag17  = 17'(mag_d);
  assign addr17 = {1'b0, req_r.payload_address};

  always_comb begin
    stat.is_free   = req_r.opcode == OP_FREE;
    stat.zero_req  = req_r.request_size == 16'd0;
    stat.bad_range = (addr17 < 17'(FIRST_HDR + HDR_BYTES)) ||
                     (addr17 >= 17'(HEAP_BYTES));
    stat.hdr_free  = rdata[HW-1];
    stat.fit       = rdata[HW-1] && (mag17 >= size17);
    stat.split     = mag17 > (size17 + 17'(HDR_BYTES));
    stat.at_target = 17'(p_r) == (addr17 - 17'(HDR_BYTES));
    stat.walk_end  = next_d >= HEAP_END;
    stat.cs_end    = c_next >= HEAP_END;
  end

  // Read address for the next cycle.
  always_comb begin
    raddr = FIRST_P;
    if (cmd.walk_adv || cmd.cfirst) begin
      raddr = next_d;
    end else if (cmd.cstep) begin
      raddr = c_next;
    end
  end

  // One header write per cycle.
  always_comb begin
    wen   = 1'b0;
    waddr = p_r;
    wdata = '0;
    if (cmd.take) begin
      wen   = 1'b1;
      wdata = stat.split ? $signed(HW'(req_r.request_size)) : $signed({1'b0, mag_d});
    end else if (cmd.split_wr) begin
      wen   = 1'b1;
      waddr = p_r + PW'(req_r.request_size) + HDR_P;
      wdata = -$signed({1'b0, AW'(mag_s - AW'(req_r.request_size) - AW'(HDR_BYTES))});
    end else if (cmd.free_mark) begin
      wen   = 1'b1;
      wdata = -rdata;
    end else if (cmd.cstep && merge) begin
      wen   = 1'b1;
      wdata = -$signed({1'b0, mag_m});
    end
  end

  ffha_ram #(
    .WIDTH(HW),
    .DEPTH(HEAP_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (wen && (waddr != FIRST_P)),
    .waddr(waddr[AW-1:0]),
    .wdata(wdata),
    .raddr(raddr[AW-1:0]),
    .rdata(ram_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr2_r <= HDR2_RESET;
      used_r <= '0;
    end else begin
      if (wen && (waddr == FIRST_P)) begin
        hdr2_r <= wdata;
      end
      if (cmd.take) begin
        used_r <= used_r + AW'(1);
      end else if (cmd.free_mark && (used_r != '0)) begin
        used_r <= used_r - AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd2_r <= raddr == FIRST_P;
    if (cmd.load) begin
      req_r  <= in_data;
      addr_r <= '0;
      gr_r   <= '0;
    end
    if (cmd.start) begin
      p_r <= FIRST_P;
    end
    if (cmd.walk_adv) begin
      p_r <= next_d;
    end
    if (cmd.take) begin
      s_r    <= rdata;
      addr_r <= AW'(p_r + HDR_P);
      gr_r   <= stat.split ? AW'(req_r.request_size) : mag_d;
    end
    if (cmd.cfirst) begin
      s_r <= rdata;
    end
    if (cmd.cstep) begin
      if (merge) begin
        s_r <= -$signed({1'b0, mag_m});
      end else begin
        p_r <= n_s;
        s_r <= rdata;
      end
    end
    if (cmd.set_st) begin
      st_r <= cmd.st;
    end
    if (cmd.finish) begin
      out_r.status         <= st_r;
      out_r.result_address <= addr_w[11:0];
      out_r.granted_size   <= gr_w[11:0];
      out_r.used_blocks    <= used_w[10:0];
    end
  end

  assign addr_w   = 32'(addr_r);
  assign gr_w     = 32'(gr_r);
  assign used_w   = 32'(used_r);
  assign out_data = out_r;

endmodule
`default_nettype wire

// ===== rtl/ffha_ctrl.sv =====
`default_nettype none
`include "first_fit_heap_allocator_macros.svh"
module ffha_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  input  wire ffha_pkg::ffha_stat_t stat,
  output ffha_pkg::ffha_cmd_t       cmd
);
  import ffha_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_CHECK, S_WALK, S_SPLIT, S_CFIRST, S_CSTEP, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (!stat.is_free && stat.zero_req) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_ZERO;
          state_nxt  = S_DONE;
        end else if (stat.is_free && stat.bad_range) begin
          cmd.set_st = 1'b1;
          cmd.st     = ST_RANGE;
          state_nxt  = S_DONE;
        end else begin
          cmd.start = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (!stat.is_free && stat.fit) begin
          cmd.take   = 1'b1;
          cmd.set_st = 1'b1;
          cmd.st     = ST_OK;
          state_nxt  = stat.split ? S_SPLIT : S_DONE;
        end else if (stat.is_free && stat.at_target) begin
          cmd.set_st = 1'b1;
          if (stat.hdr_free) begin
            cmd.st    = ST_DOUBLE;
            state_nxt = S_DONE;
          end else begin
            cmd.st        = ST_OK;
            cmd.free_mark = 1'b1;
            cmd.start     = 1'b1;
            state_nxt     = S_CFIRST;
          end
        end else if (stat.walk_end) begin
          cmd.set_st = 1'b1;
          cmd.st     = stat.is_free ? ST_NOTALLOC : ST_NOSPACE;
          state_nxt  = S_DONE;
        end else begin
          cmd.walk_adv = 1'b1;
        end
      end
      S_SPLIT: begin
        cmd.split_wr = 1'b1;
        state_nxt    = S_DONE;
      end
      S_CFIRST: begin
        cmd.cfirst = 1'b1;
        state_nxt  = stat.walk_end ? S_DONE : S_CSTEP;
      end
      S_CSTEP: begin
        cmd.cstep = 1'b1;
        if (stat.cs_end) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `FFHA_ASSERT_NXT(a_result_held, out_valid_r && out_stall, out_valid_r, "result dropped")
  `FFHA_ASSERT_NXT(a_accept_check, in_valid && !in_stall, state_r == S_CHECK, "accept lost")
  `FFHA_ASSERT_IMP(a_finish_free, cmd.finish, out_free && state_r == S_DONE, "result overrun")
  `FFHA_ASSERT_IMP(a_one_write, cmd.take, !cmd.free_mark && !cmd.cstep, "write clash")

endmodule
`default_nettype wire
